>>> src/uniform_graph_random_walk_macros.svh
// Assertion macros for the uniform graph random walk block.
`ifndef UNIFORM_GRAPH_RANDOM_WALK_MACROS_SVH
`define UNIFORM_GRAPH_RANDOM_WALK_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define UGRW_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define UGRW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/ugrw_pkg.sv
// Shared types and constants of the uniform graph random walk block.
package ugrw_pkg;

    localparam int DEG_W      = 13;
    localparam int NODE_W     = 10;
    localparam int EIDX_W     = 12;
    localparam int STEP_W     = 6;
    localparam int OP_W       = 2;
    localparam int NCNT_W     = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int LFSR_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int PROD_W     = FRAC_W + DEG_W;

    localparam logic [DEG_W-1:0]  DEG_MAX    = 13'd8191;
    localparam logic [LFSR_W-1:0] LFSR_MASK  = 32'h8020_0003;
    localparam logic [LFSR_W-1:0] LFSR_RESET = 32'd1;

    localparam logic [STEP_W-1:0] WALK_STEPS_RESET  = 6'd4;
    localparam logic [NCNT_W-1:0] NODE_COUNT_RESET  = 11'd1024;
    localparam logic [LFSR_W-1:0] RANDOM_SEED_RESET = 32'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_WALK_STEPS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_SEED = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR    = 2'd0,
        OP_LOAD     = 2'd1,
        OP_FINALIZE = 2'd2,
        OP_WALK     = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_LD_RD,
        ST_LD_WR,
        ST_FIN_RD,
        ST_FIN_WR,
        ST_W_START,
        ST_W_RD,
        ST_W_CHK,
        ST_W_DRAW,
        ST_W_MUL,
        ST_W_ADDR,
        ST_W_TGT,
        ST_W_DEAD
    } state_t;

    typedef struct packed {
        logic load;
        logic advance;
    } lfsr_ctrl_t;

endpackage

>>> src/uniform_graph_random_walk.sv
// Top level of the uniform random walk over a compressed-row graph.
// Walk: a start result, then per live step a degree/offset read, two LFSR advances,
//   a multiply, an address add and a target read; results wait while the output stalls,
//   and after a dead end the remaining steps come out as dead results.
// Reset: a clearing pass writes zero to all MAX_NODES degree entries, one per cycle,
//   with in_ready low; the LFSR comes up as 1 and registers at their reset values.
`include "uniform_graph_random_walk_macros.svh"

module uniform_graph_random_walk
    import ugrw_pkg::*;
#(
    parameter int MAX_NODES = 1024,
    parameter int MAX_EDGES = 4096,
    parameter int MAX_WALK  = 63
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input beats
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [OP_W-1:0]       op,
    input  logic [EIDX_W-1:0]     edge_index,
    input  logic [NODE_W-1:0]     edge_source,
    input  logic [NODE_W-1:0]     edge_target,
    input  logic [NODE_W-1:0]     start_node,
    // result beats
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [NODE_W-1:0]     node,
    output logic [STEP_W-1:0]     step,
    output logic                  valid_res,
    output logic                  last
);

    localparam int NODE_AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int EDGE_AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int NODE_CW = $clog2(MAX_NODES + 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [STEP_W-1:0] walk_steps_reg;
    logic [NCNT_W-1:0] node_count_reg;
    logic [LFSR_W-1:0] random_seed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_steps_reg  <= WALK_STEPS_RESET;
            node_count_reg  <= NODE_COUNT_RESET;
            random_seed_reg <= RANDOM_SEED_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_WALK_STEPS:  walk_steps_reg  <= cfg_data[STEP_W-1:0];
                CFG_NODE_COUNT:  node_count_reg  <= cfg_data[NCNT_W-1:0];
                CFG_RANDOM_SEED: random_seed_reg <= cfg_data[LFSR_W-1:0];
                default:         ; // index beyond the list: dropped
            endcase
        end
    end

    // Nodes in use and walk length, both clamped to the build limits.
    logic [NODE_CW-1:0] nodes_used;
    logic [STEP_W-1:0]  steps_cfg;

    assign nodes_used = (32'(node_count_reg) > MAX_NODES) ? NODE_CW'(MAX_NODES)
                                                          : NODE_CW'(node_count_reg);
    assign steps_cfg  = (32'(walk_steps_reg) > MAX_WALK) ? STEP_W'(MAX_WALK)
                                                         : walk_steps_reg;

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    state_t             state_reg,      state_next;
    logic [NODE_CW-1:0] idx_reg,        idx_next;
    logic [DEG_W-1:0]   sum_reg,        sum_next;
    logic [STEP_W-1:0]  step_cnt_reg,   step_cnt_next;
    logic [STEP_W-1:0]  step_total_reg, step_total_next;
    logic [NODE_W-1:0]  cur_reg,        cur_next;
    logic               cur_ok_reg,     cur_ok_next;
    logic               out_valid_reg,  out_valid_next;

    // payload registers
    logic [EIDX_W-1:0]  e_index_reg;
    logic [NODE_W-1:0]  e_source_reg;
    logic [NODE_W-1:0]  e_target_reg;
    logic [PROD_W-1:0]  prod_reg,       prod_next;
    logic [NODE_W-1:0]  out_node_reg,   out_node_next;
    logic [STEP_W-1:0]  out_step_reg,   out_step_next;
    logic               out_vres_reg,   out_vres_next;
    logic               out_last_reg,   out_last_next;

    // memory read data
    logic [DEG_W-1:0]   deg_rd_reg;
    logic [DEG_W-1:0]   off_rd_reg;
    logic [NODE_W-1:0]  tgt_rd_reg;

    // memory ports
    logic               deg_we, deg_re;
    logic [NODE_AW-1:0] deg_waddr, deg_raddr;
    logic [DEG_W-1:0]   deg_wdata;
    logic               off_we, off_re;
    logic [NODE_AW-1:0] off_waddr, off_raddr;
    logic [DEG_W-1:0]   off_wdata;
    logic               tgt_we, tgt_re;
    logic [EDGE_AW-1:0] tgt_waddr, tgt_raddr;
    logic [NODE_W-1:0]  tgt_wdata;

    lfsr_ctrl_t         lfsr_ctrl;
    logic [FRAC_W-1:0]  frac;

    logic               in_fire;
    logic               out_free;
    logic               load_ok;
    logic               step_last;
    logic [DEG_W:0]     sum_wide;
    logic [DEG_W:0]     walk_addr;
    logic               walk_addr_ok;
    logic [31:0]        idx_w, cur_w, esrc_w, eidx_w, waddr_w;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    // Output register can take a beat if empty or being drained this cycle.
    assign out_free = !out_valid_reg || out_ready;

    assign idx_w   = 32'(idx_reg);
    assign cur_w   = 32'(cur_reg);
    assign esrc_w  = 32'(e_source_reg);
    assign eidx_w  = 32'(e_index_reg);

    // Out-of-range loads are dropped entirely.
    assign load_ok = (eidx_w < MAX_EDGES) && (esrc_w < MAX_NODES);

    // Prefix-sum adder, saturating.
    assign sum_wide = {1'b0, sum_reg} + {1'b0, deg_rd_reg};

    // Edge address: row offset plus scaled fraction.
    assign walk_addr    = {1'b0, off_rd_reg} + {1'b0, prod_reg[PROD_W-1:FRAC_W]};
    assign waddr_w      = 32'(walk_addr);
    assign walk_addr_ok = waddr_w < MAX_EDGES;

    assign step_last = (step_cnt_reg == step_total_reg);

    // ------------------------------------------------------------------
    // Next state, memory control and result emission
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        sum_next        = sum_reg;
        step_cnt_next   = step_cnt_reg;
        step_total_next = step_total_reg;
        cur_next        = cur_reg;
        cur_ok_next     = cur_ok_reg;
        prod_next       = prod_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_node_next   = out_node_reg;
        out_step_next   = out_step_reg;
        out_vres_next   = out_vres_reg;
        out_last_next   = out_last_reg;

        deg_we    = 1'b0;
        deg_waddr = esrc_w[NODE_AW-1:0];
        deg_wdata = '0;
        deg_re    = 1'b0;
        deg_raddr = esrc_w[NODE_AW-1:0];
        off_we    = 1'b0;
        off_waddr = idx_w[NODE_AW-1:0];
        off_wdata = sum_reg;
        off_re    = 1'b0;
        off_raddr = cur_w[NODE_AW-1:0];
        tgt_we    = 1'b0;
        tgt_waddr = eidx_w[EDGE_AW-1:0];
        tgt_wdata = e_target_reg;
        tgt_re    = 1'b0;
        tgt_raddr = waddr_w[EDGE_AW-1:0];

        lfsr_ctrl = '0;

        unique case (state_reg)
            ST_CLR:
            begin
                deg_we    = 1'b1;
                deg_waddr = idx_w[NODE_AW-1:0];
                deg_wdata = '0;
                if (idx_reg == NODE_CW'(MAX_NODES - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (op_t'(op))
                        OP_CLEAR:
                        begin
                            lfsr_ctrl.load = 1'b1;
                            idx_next       = '0;
                            state_next     = ST_CLR;
                        end
                        OP_LOAD:
                        begin
                            state_next = ST_LD_RD;
                        end
                        OP_FINALIZE:
                        begin
                            idx_next   = '0;
                            sum_next   = '0;
                            state_next = ST_FIN_RD;
                        end
                        OP_WALK:
                        begin
                            cur_next        = start_node;
                            step_cnt_next   = '0;
                            step_total_next = steps_cfg;
                            state_next      = ST_W_START;
                        end
                    endcase
                end
            end

            ST_LD_RD:
            begin
                if (load_ok)
                begin
                    tgt_we     = 1'b1;
                    deg_re     = 1'b1;
                    state_next = ST_LD_WR;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_LD_WR:
            begin
                deg_we     = 1'b1;
                deg_wdata  = (deg_rd_reg == DEG_MAX) ? deg_rd_reg : deg_rd_reg + 1'b1;
                state_next = ST_IDLE;
            end

            ST_FIN_RD:
            begin
                if (idx_reg == nodes_used)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    deg_re     = 1'b1;
                    deg_raddr  = idx_w[NODE_AW-1:0];
                    state_next = ST_FIN_WR;
                end
            end

            ST_FIN_WR:
            begin
                off_we     = 1'b1;
                sum_next   = (sum_wide > {1'b0, DEG_MAX}) ? DEG_MAX : sum_wide[DEG_W-1:0];
                idx_next   = idx_reg + 1'b1;
                state_next = ST_FIN_RD;
            end

            ST_W_START:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_node_next  = cur_reg;
                    out_step_next  = '0;
                    out_vres_next  = 1'b1;
                    out_last_next  = (step_total_reg == '0);
                    if (step_total_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        step_cnt_next = step_cnt_reg + 1'b1;
                        state_next    = ST_W_RD;
                    end
                end
            end

            ST_W_RD:
            begin
                deg_re      = 1'b1;
                deg_raddr   = cur_w[NODE_AW-1:0];
                off_re      = 1'b1;
                cur_ok_next = cur_w < 32'(nodes_used);
                state_next  = ST_W_CHK;
            end

            ST_W_CHK:
            begin
                if (!cur_ok_reg || (deg_rd_reg == '0))
                begin
                    state_next = ST_W_DEAD;
                end
                else
                begin
                    lfsr_ctrl.advance = 1'b1;
                    state_next        = ST_W_DRAW;
                end
            end

            ST_W_DRAW:
            begin
                lfsr_ctrl.advance = 1'b1;
                state_next        = ST_W_MUL;
            end

            ST_W_MUL:
            begin
                prod_next  = PROD_W'(frac) * PROD_W'(deg_rd_reg);
                state_next = ST_W_ADDR;
            end

            ST_W_ADDR:
            begin
                if (walk_addr_ok)
                begin
                    tgt_re     = 1'b1;
                    state_next = ST_W_TGT;
                end
                else
                begin
                    state_next = ST_W_DEAD;
                end
            end

            ST_W_TGT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_node_next  = tgt_rd_reg;
                    out_step_next  = step_cnt_reg;
                    out_vres_next  = 1'b1;
                    out_last_next  = step_last;
                    cur_next       = tgt_rd_reg;
                    if (step_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        step_cnt_next = step_cnt_reg + 1'b1;
                        state_next    = ST_W_RD;
                    end
                end
            end

            ST_W_DEAD:
            begin
                // walk stopped: fill the remaining positions, no more draws
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_node_next  = '0;
                    out_step_next  = step_cnt_reg;
                    out_vres_next  = 1'b0;
                    out_last_next  = step_last;
                    if (step_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        step_cnt_next = step_cnt_reg + 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLR;
            idx_reg        <= '0;
            sum_reg        <= '0;
            step_cnt_reg   <= '0;
            step_total_reg <= '0;
            cur_reg        <= '0;
            cur_ok_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            sum_reg        <= sum_next;
            step_cnt_reg   <= step_cnt_next;
            step_total_reg <= step_total_next;
            cur_reg        <= cur_next;
            cur_ok_reg     <= cur_ok_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            e_index_reg  <= edge_index;
            e_source_reg <= edge_source;
            e_target_reg <= edge_target;
        end
        prod_reg     <= prod_next;
        out_node_reg <= out_node_next;
        out_step_reg <= out_step_next;
        out_vres_reg <= out_vres_next;
        out_last_reg <= out_last_next;
    end

    // ------------------------------------------------------------------
    // Stores: degree, row offset, edge target
    // ------------------------------------------------------------------
    logic [DEG_W-1:0]  deg_mem [MAX_NODES];
    logic [DEG_W-1:0]  off_mem [MAX_NODES];
    logic [NODE_W-1:0] tgt_mem [MAX_EDGES];

    always_ff @(posedge clk)
    begin
        if (deg_we)
        begin
            deg_mem[deg_waddr] <= deg_wdata;
        end
        if (deg_re)
        begin
            deg_rd_reg <= deg_mem[deg_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (off_we)
        begin
            off_mem[off_waddr] <= off_wdata;
        end
        if (off_re)
        begin
            off_rd_reg <= off_mem[off_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tgt_we)
        begin
            tgt_mem[tgt_waddr] <= tgt_wdata;
        end
        if (tgt_re)
        begin
            tgt_rd_reg <= tgt_mem[tgt_raddr];
        end
    end

    // ------------------------------------------------------------------
    // Random source
    // ------------------------------------------------------------------
    ugrw_lfsr u_lfsr
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (lfsr_ctrl),
        .seed  (random_seed_reg),
        .frac  (frac)
    );

    assign out_valid = out_valid_reg;
    assign node      = out_node_reg;
    assign step      = out_step_reg;
    assign valid_res = out_vres_reg;
    assign last      = out_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `UGRW_ASSERT_IMPL(a_dead_node_zero, clk, rst_n, out_valid_reg && !out_vres_reg, out_node_reg == '0, "dead-end beat carries a nonzero node")
    `UGRW_ASSERT_IMPL(a_step_bound, clk, rst_n, out_valid_reg && (state_reg != ST_IDLE), out_step_reg <= step_total_reg, "result step beyond walk length")
    `UGRW_ASSERT_IMPL(a_idle_last, clk, rst_n, out_valid_reg && (state_reg == ST_IDLE), out_last_reg, "sequencer idle before final beat of walk")
    `UGRW_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_fire, !in_ready, "ready held high right after an accepted beat")

endmodule

>>> src/ugrw_lfsr.sv
// Galois LFSR, eight right shifts per advance, seed load with lock-up guard.
module ugrw_lfsr
    import ugrw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  lfsr_ctrl_t        ctrl,
    input  logic [LFSR_W-1:0] seed,
    output logic [FRAC_W-1:0] frac
);

    logic [LFSR_W-1:0] lfsr_reg;
    logic [LFSR_W-1:0] lfsr_next;
    logic [LFSR_W-1:0] shifted;

    function automatic logic [LFSR_W-1:0] shift8(input logic [LFSR_W-1:0] v);
        logic [LFSR_W-1:0] s;
        s = v;
        for (int k = 0; k < 8; k++)
        begin
            s = s[0] ? ((s >> 1) ^ LFSR_MASK) : (s >> 1);
        end
        return s;
    endfunction

    assign shifted = shift8(lfsr_reg);

    always_comb
    begin
        lfsr_next = lfsr_reg;
        if (ctrl.load)
        begin
            lfsr_next = (seed == '0) ? LFSR_RESET : seed;
        end
        else if (ctrl.advance)
        begin
            lfsr_next = shifted;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg <= LFSR_RESET;
        end
        else
        begin
            lfsr_reg <= lfsr_next;
        end
    end

    assign frac = lfsr_reg[LFSR_W-1:LFSR_W-FRAC_W];

endmodule
